@@ rtl/hpg_pkg.sv @@
// Package for the height palette gradient block: widths, register codes, palette helpers.
package hpg_pkg;

  localparam int PALETTE_SIZE = 8;
  localparam int IDX_W        = $clog2(PALETTE_SIZE);
  localparam int HEIGHT_W     = 16;
  localparam int GAIN_W       = 32;
  localparam int POS_W        = 16;
  localparam int COLOR_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int PAIR_W       = 2 * COLOR_W;
  localparam int NUM_PAIRS    = PALETTE_SIZE / 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = PAIR_W;
  localparam int COUNT_W      = 4;
  localparam int PROD_W       = HEIGHT_W + GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_3 = 3'd6;

  localparam logic [COUNT_W-1:0] COUNT_MIN   = 4'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'(PALETTE_SIZE);
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

  typedef logic [NUM_PAIRS-1:0][PAIR_W-1:0] pal_pairs_t;
  typedef logic [COLOR_W-1:0]               color_t;

  function automatic color_t palette_color(input pal_pairs_t pairs,
                                           input logic [IDX_W-1:0] idx);
    logic [PAIR_W-1:0] pair;
    pair = pairs[idx[IDX_W-1:1]];
    return idx[0] ? pair[PAIR_W-1:COLOR_W] : pair[COLOR_W-1:0];
  endfunction

  // lo + floor((hi - lo) * blend / 2^16), kept to 8 bits
  function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] lo,
                                                   input logic [CHAN_W-1:0] hi,
                                                   input logic [POS_W-1:0]  blend);
    logic signed [CHAN_W:0]         diff;
    logic signed [CHAN_W+POS_W+1:0] prod;
    logic signed [CHAN_W+1:0]       step;
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod = diff * $signed({1'b0, blend});
    step = prod[CHAN_W+POS_W+1:POS_W];
    return lo + step[CHAN_W-1:0];
  endfunction

endpackage

@@ rtl/hpg_if.sv @@
// Stream interfaces of the height palette gradient block.
interface hpg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [hpg_pkg::HEIGHT_W-1:0] height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink   (input valid, input height_sample, output ready);
endinterface

interface hpg_out_if;
  logic                         valid;
  logic                         ready;
  logic [hpg_pkg::CHAN_W-1:0]   red;
  logic [hpg_pkg::CHAN_W-1:0]   green;
  logic [hpg_pkg::CHAN_W-1:0]   blue;
  logic [hpg_pkg::IDX_W-1:0]    color_index;

  modport source (output valid, output red, output green, output blue, output color_index,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input color_index,
                  output ready);
endinterface

@@ rtl/height_palette_gradient_top.sv @@
// Height palette gradient: four-stage pipeline mapping height samples to blended RGB colors.
// One item per cycle sustained while the output is not stalled. Stage 1 holds the 16x32
// height-by-gain product, stage 2 the biased and clamped ramp position, stage 3 the palette
// index, blend weight and the two neighboring colors, stage 4 the blended channels. Each
// stage takes a new item when empty or when the stage after it moves, so the pipeline fills
// bubbles and holds every item under back-pressure. Configuration registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while idle, and the
// block itself does not enforce this.
module height_palette_gradient_top (
  input  logic                               clk,
  input  logic                               rst_n,
  hpg_in_if.sink                             in_ch,
  hpg_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [hpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hpg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration
  logic signed [hpg_pkg::GAIN_W-1:0] gain_r;
  logic signed [hpg_pkg::GAIN_W-1:0] bias_r;
  logic [hpg_pkg::COUNT_W-1:0]       count_r;
  hpg_pkg::pal_pairs_t               pairs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= '0;
      bias_r  <= '0;
      count_r <= hpg_pkg::COUNT_RESET;
      pairs_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpg_pkg::REG_GAIN:   gain_r     <= $signed(cfg_data[hpg_pkg::GAIN_W-1:0]);
        hpg_pkg::REG_BIAS:   bias_r     <= $signed(cfg_data[hpg_pkg::GAIN_W-1:0]);
        hpg_pkg::REG_COUNT:  count_r    <= cfg_data[hpg_pkg::COUNT_W-1:0];
        hpg_pkg::REG_PAIR_0: pairs_r[0] <= cfg_data;
        hpg_pkg::REG_PAIR_1: pairs_r[1] <= cfg_data;
        hpg_pkg::REG_PAIR_2: pairs_r[2] <= cfg_data;
        hpg_pkg::REG_PAIR_3: pairs_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped count minus one, 1..PALETTE_SIZE-1
  logic [hpg_pkg::COUNT_W-1:0] count_c;
  logic [hpg_pkg::IDX_W-1:0]   span;
  always_comb begin
    if (count_r < hpg_pkg::COUNT_MIN)      count_c = hpg_pkg::COUNT_MIN;
    else if (count_r > hpg_pkg::COUNT_MAX) count_c = hpg_pkg::COUNT_MAX;
    else                                   count_c = count_r;
  end
  assign span = hpg_pkg::IDX_W'(count_c - 4'd1);

  // stage valids and flow control
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: height times gain
  logic signed [hpg_pkg::PROD_W-1:0] prod_r;
  always_ff @(posedge clk) begin
    if (rdy1) prod_r <= in_ch.height_sample * gain_r;
  end

  // stage 2: floor shift, bias, clamp to the ramp
  localparam int SUM_W = hpg_pkg::GAIN_W + 2;
  logic signed [SUM_W-1:0]       sum;
  logic [hpg_pkg::POS_W-1:0]     pos_nxt;
  logic [hpg_pkg::POS_W-1:0]     pos_r;
  always_comb begin
    sum = SUM_W'(prod_r >>> hpg_pkg::POS_W) + SUM_W'(bias_r);
    if (sum < 0)
      pos_nxt = '0;
    else if (sum > $signed({{(SUM_W-hpg_pkg::POS_W){1'b0}}, {hpg_pkg::POS_W{1'b1}}}))
      pos_nxt = '1;
    else
      pos_nxt = sum[hpg_pkg::POS_W-1:0];
  end
  always_ff @(posedge clk) begin
    if (rdy2) pos_r <= pos_nxt;
  end

  // stage 3: palette position, neighbor colors
  localparam int SCALED_W = hpg_pkg::POS_W + hpg_pkg::IDX_W;
  logic [SCALED_W-1:0]         scaled;
  logic [hpg_pkg::IDX_W-1:0]   idx;
  logic [hpg_pkg::IDX_W-1:0]   idx_r;
  logic [hpg_pkg::POS_W-1:0]   blend_r;
  hpg_pkg::color_t             clo_r, chi_r;
  assign scaled = SCALED_W'(pos_r) * SCALED_W'(span);
  assign idx    = scaled[SCALED_W-1:hpg_pkg::POS_W];
  always_ff @(posedge clk) begin
    if (rdy3) begin
      idx_r   <= idx;
      blend_r <= scaled[hpg_pkg::POS_W-1:0];
      clo_r   <= hpg_pkg::palette_color(pairs_r, idx);
      chi_r   <= hpg_pkg::palette_color(pairs_r, idx + 1'b1);
    end
  end

  // stage 4: blend the three channels
  logic [hpg_pkg::CHAN_W-1:0] red_r, green_r, blue_r;
  logic [hpg_pkg::IDX_W-1:0]  cidx_r;
  always_ff @(posedge clk) begin
    if (rdy4) begin
      red_r   <= hpg_pkg::blend_chan(clo_r[23:16], chi_r[23:16], blend_r);
      green_r <= hpg_pkg::blend_chan(clo_r[15:8],  chi_r[15:8],  blend_r);
      blue_r  <= hpg_pkg::blend_chan(clo_r[7:0],   chi_r[7:0],   blend_r);
      cidx_r  <= idx_r;
    end
  end

  assign out_ch.valid       = v4_r;
  assign out_ch.red         = red_r;
  assign out_ch.green       = green_r;
  assign out_ch.blue        = blue_r;
  assign out_ch.color_index = cidx_r;

endmodule

@@ rtl/hpg_checker.sv @@
// Port-level checks for the height palette gradient top level, with its bind.
module hpg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [hpg_pkg::CHAN_W-1:0]        out_red,
  input logic [hpg_pkg::CHAN_W-1:0]        out_green,
  input logic [hpg_pkg::CHAN_W-1:0]        out_blue,
  input logic [hpg_pkg::IDX_W-1:0]         out_color_index
);

  localparam logic [hpg_pkg::IDX_W-1:0] IDX_TOP = '1;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) &&
                                $stable(out_blue) && $stable(out_color_index))
    else $error("out item changed while stalled");

  // empty output stage means every stage can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output stage empty");

  // the lower entry is never the last palette slot
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_color_index != IDX_TOP)
    else $error("color index out of range");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

endmodule

bind height_palette_gradient_top hpg_checker u_hpg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_red         (out_ch.red),
  .out_green       (out_ch.green),
  .out_blue        (out_ch.blue),
  .out_color_index (out_ch.color_index)
);

@@ sim/hpg_gradient_checker.sv @@
// Scoreboard for the height palette gradient: shadows the registers, predicts and checks colors.
module hpg_gradient_checker
  import hpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  hpg_in_if                     in_mon,
  hpg_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    colors_pending
);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [IDX_W-1:0]  color_index;
  } ramp_color_t;

  ramp_color_t color_queue [$];

  logic signed [GAIN_W-1:0] gain_q;
  logic signed [GAIN_W-1:0] bias_q;
  logic [COUNT_W-1:0]       count_q;
  logic [PAIR_W-1:0]        pair_q [NUM_PAIRS];
  int                       errs;

  function automatic logic [COLOR_W-1:0] palette_entry(input logic [IDX_W-1:0] slot);
    logic [PAIR_W-1:0] pair;
    pair = pair_q[slot >> 1];
    return slot[0] ? pair[PAIR_W-1 -: COLOR_W] : pair[COLOR_W-1:0];
  endfunction

  function automatic ramp_color_t predict_color(input logic signed [HEIGHT_W-1:0] h);
    longint             prod;
    longint             pos;
    int                 span;
    int                 scaled;
    int                 blend;
    int                 lo;
    int                 hi;
    int                 ch;
    logic [IDX_W-1:0]   slot;
    logic [COLOR_W-1:0] c_lo;
    logic [COLOR_W-1:0] c_hi;
    logic [CHAN_W-1:0]  mixed [3];
    ramp_color_t        r;
    prod = longint'(h) * longint'(gain_q);
    // arithmetic shift of a signed value rounds toward minus infinity
    pos = (prod >>> POS_W) + longint'(bias_q);
    if (pos < 0) pos = 0;
    else if (pos > 65535) pos = 65535;
    if (count_q < COUNT_MIN) span = int'(COUNT_MIN) - 1;
    else if (count_q > COUNT_MAX) span = int'(COUNT_MAX) - 1;
    else span = int'(count_q) - 1;
    scaled = int'(pos) * span;
    slot = IDX_W'(scaled >> POS_W);
    blend = scaled & 32'h0000_FFFF;
    c_lo = palette_entry(slot);
    c_hi = palette_entry(slot + 1'b1);
    for (ch = 0; ch < 3; ch++) begin
      lo = int'(c_lo[ch*CHAN_W +: CHAN_W]);
      hi = int'(c_hi[ch*CHAN_W +: CHAN_W]);
      mixed[ch] = CHAN_W'(lo + (((hi - lo) * blend) >>> POS_W));
    end
    r.red         = mixed[2];
    r.green       = mixed[1];
    r.blue        = mixed[0];
    r.color_index = slot;
    return r;
  endfunction

  always @(posedge clk) begin
    ramp_color_t exp_c;
    if (!rst_n) begin
      gain_q  = '0;
      bias_q  = '0;
      count_q = COUNT_RESET;
      for (int p = 0; p < NUM_PAIRS; p++) pair_q[p] = '0;
      color_queue.delete();
      errs = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN:   gain_q = cfg_data[GAIN_W-1:0];
          REG_BIAS:   bias_q = cfg_data[GAIN_W-1:0];
          REG_COUNT:  count_q = cfg_data[COUNT_W-1:0];
          REG_PAIR_0: pair_q[0] = cfg_data;
          REG_PAIR_1: pair_q[1] = cfg_data;
          REG_PAIR_2: pair_q[2] = cfg_data;
          REG_PAIR_3: pair_q[3] = cfg_data;
          default: ;  // unused index, no effect
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        color_queue.push_back(predict_color(in_mon.height_sample));
      if (out_mon.valid && out_mon.ready) begin
        if (color_queue.size() == 0) begin
          $error("color item with nothing expected: r %0d g %0d b %0d idx %0d",
                 out_mon.red, out_mon.green, out_mon.blue, out_mon.color_index);
          errs++;
        end else begin
          exp_c = color_queue.pop_front();
          if (out_mon.red !== exp_c.red) begin
            $error("red: expected %0d, got %0d", exp_c.red, out_mon.red);
            errs++;
          end
          if (out_mon.green !== exp_c.green) begin
            $error("green: expected %0d, got %0d", exp_c.green, out_mon.green);
            errs++;
          end
          if (out_mon.blue !== exp_c.blue) begin
            $error("blue: expected %0d, got %0d", exp_c.blue, out_mon.blue);
            errs++;
          end
          if (out_mon.color_index !== exp_c.color_index) begin
            $error("color_index: expected %0d, got %0d", exp_c.color_index,
                   out_mon.color_index);
            errs++;
          end
        end
      end
    end
    fail_count     <= errs;
    colors_pending <= color_queue.size();
  end

endmodule

@@ sim/tb_height_palette_gradient_top.sv @@
// Testbench top for the height palette gradient: clock, reset, stimulus and verdict.
module tb_height_palette_gradient_top;
  import hpg_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_SLACK  = 8;     // pipeline depth plus margin
  localparam int RANDOM_ITEMS = 1750;
  localparam int SEGMENTS     = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int tx_idle_pct = 22;
  int rx_idle_pct = 52;
  int fail_count;
  int colors_pending;
  int cycle_count;
  int items_sent;
  int settings_loaded;

  hpg_in_if  in_ch ();
  hpg_out_if out_ch ();

  height_palette_gradient_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hpg_gradient_checker color_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .colors_pending (colors_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_height(input logic signed [HEIGHT_W-1:0] h);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.height_sample <= h;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // stop sending and wait until every expected color is out
  task automatic wait_colors_out;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (colors_pending != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // writes all registers, junk in the unused upper data bits, then the unused index
  task automatic load_ramp(input logic [GAIN_W-1:0] gain, input logic [GAIN_W-1:0] bias,
                           input logic [COUNT_W-1:0] count,
                           input logic [PAIR_W-1:0] p0, input logic [PAIR_W-1:0] p1,
                           input logic [PAIR_W-1:0] p2, input logic [PAIR_W-1:0] p3);
    logic [CFG_DATA_W-1:0] image [8];
    int i;
    image[REG_GAIN]   = {16'($urandom), gain};
    image[REG_BIAS]   = {16'($urandom), bias};
    image[REG_COUNT]  = {44'({$urandom, $urandom}), count};
    image[REG_PAIR_0] = p0;
    image[REG_PAIR_1] = p1;
    image[REG_PAIR_2] = p2;
    image[REG_PAIR_3] = p3;
    image[REG_UNUSED] = CFG_DATA_W'({$urandom, $urandom});
    for (i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= image[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  initial begin
    logic signed [HEIGHT_W-1:0] h;
    logic [GAIN_W-1:0]          gain;
    logic [GAIN_W-1:0]          bias;
    logic [COUNT_W-1:0]         count;
    int                         ramp_span;
    int                         kind;
    int                         seg;
    int                         n;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.height_sample <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    items_sent      = 0;
    settings_loaded = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: everything lands on color 0, all black
    send_height(16'sd0);
    send_height(16'sh7FFF);
    send_height(16'sh8000);
    wait_colors_out();

    // full ramp over -16384..16384, rising, falling and mixed blends, bottom and top clamp
    load_ramp(32'd131072, 32'd32768, 4'd8, 48'hFFFFFF_000000, 48'h000000_FFFFFF,
              48'h123456_ABCDEF, 48'h00FF00_FF00FF);
    send_height(16'sh8000);
    send_height(-16'sd16384);
    send_height(-16'sd16385);
    send_height(16'sd0);
    send_height(-16'sd1);
    send_height(16'sd1);
    send_height(16'sd8192);
    send_height(16'sd16383);
    send_height(16'sd16384);
    send_height(16'sh7FFF);
    wait_colors_out();

    // largest gain, count zero taken as two
    load_ramp(32'h7FFF_FFFF, 32'd0, 4'd0, 48'hFFFFFF_FFFFFF, 48'h0,
              48'hA5A5A5_5A5A5A, 48'h0F0F0F_F0F0F0);
    send_height(16'sh7FFF);
    send_height(16'sh8000);
    send_height(16'sd1);
    send_height(-16'sd1);
    wait_colors_out();

    // most negative gain, largest bias, count above the palette size
    load_ramp(32'h8000_0000, 32'h7FFF_FFFF, 4'd15, 48'h010203_FEFDFC, 48'h808080_7F7F7F,
              48'hFF0000_00FF00, 48'h0000FF_FFFFFF);
    send_height(16'sh7FFF);
    send_height(16'sh8000);
    send_height(-16'sd1);
    send_height(16'sd0);
    wait_colors_out();

    // count of one taken as two, smallest bias
    load_ramp(32'd65536, 32'h8000_0000, 4'd1, 48'h00FF80_FF0080, 48'h0,
              48'h0, 48'h0);
    send_height(16'sh7FFF);
    send_height(16'sd5);
    wait_colors_out();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin tx_idle_pct = 22; rx_idle_pct = 52; end
        1: begin tx_idle_pct = 52; rx_idle_pct = 22; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      kind = (seg == 0) ? 0 : $urandom_range(3);
      ramp_span = 1024;
      case (kind)
        0: begin
          ramp_span = $urandom_range(32768, 2);
          gain = 32'(64'h8000_0000 / longint'(ramp_span));
          bias = 32'(32768 + $urandom_range(8192) - 4096);
        end
        1: begin
          gain = $urandom;
          bias = $urandom;
        end
        2: begin
          ramp_span = 16384;
          gain = 32'(int'($urandom_range(262143)) - 131072);
          bias = 32'(int'($urandom_range(196607)) - 65536);
        end
        default: begin
          gain = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          case ($urandom_range(2))
            0:       bias = 32'h8000_0000;
            1:       bias = 32'h7FFF_FFFF;
            default: bias = 32'd32768;
          endcase
        end
      endcase
      if (seg == 0) count = 4'd2;
      else if (seg == 1) count = 4'd8;
      else if ($urandom_range(3) == 0) count = 4'($urandom_range(15));
      else count = 4'($urandom_range(8, 2));
      load_ramp(gain, bias, count, PAIR_W'({$urandom, $urandom}),
                PAIR_W'({$urandom, $urandom}), PAIR_W'({$urandom, $urandom}),
                PAIR_W'({$urandom, $urandom}));
      for (n = 0; n < RANDOM_ITEMS / SEGMENTS; n++) begin
        if ($urandom_range(9) < 4) h = HEIGHT_W'($urandom);
        else h = HEIGHT_W'(int'($urandom_range(2 * ramp_span)) - ramp_span);
        send_height(h);
      end
      wait_colors_out();
    end

    $display("%0d height items over %0d palette settings, count and gain extremes included",
             items_sent, settings_loaded);
    $display("idle mix sender/receiver 22/52, then 52/22, then none; %0d cycles",
             cycle_count);
    if (fail_count == 0 && colors_pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hpg_pkg.sv
rtl/hpg_if.sv
rtl/height_palette_gradient_top.sv
rtl/hpg_checker.sv
sim/hpg_gradient_checker.sv
sim/tb_height_palette_gradient_top.sv
